FILE: design/swc_pkg.sv
`default_nettype none

package swc_pkg;

	// Defaults for the top level parameters
	localparam int ADDR_BITS_DEF   = 16;
	localparam int OFFSET_BITS_DEF = 6;
	localparam int SET_BITS_DEF    = 6;
	localparam int WAYS_DEF        = 4;

	// Fixed field widths on the ports
	localparam int ADDR_W = 16;
	localparam int BYTE_W = 8;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_STORE = 2'd1,
		OP_INV   = 2'd2,
		OP_FLUSH = 2'd3
	} op_t;

	// Controller to datapath
	typedef struct packed {
		logic clr;       // zero one backing row, step sweep counter
		logic cap;       // capture request, read tag row
		logic res_hit;   // latch lookup outcome
		logic flush;     // drop every line
		logic inv;       // drop the matching line
		logic hit_wr;    // update tag row on hit, read hit line
		logic hdata;     // load byte / merge store byte on hit line
		logic row_ld;    // copy tag row into the victim search row
		logic vic_inv;   // victim is the first invalid way
		logic vic_walk;  // victim is the walked way
		logic clr_acc;   // clear accessed of the walked way
		logic clr_dirty; // clear dirty of the walked way
		logic wb_rd;     // read walked line
		logic wb_wr;     // write walked line to backing memory
		logic fill_rd;   // read backing line
		logic fill_wr;   // install line and tag
		logic out_ld;    // load output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic hit;
		logic any_inv;
		logic cur_acc;
		logic cur_dirty;
		logic clr_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: design/swc_dp.sv
`default_nettype none

module swc_dp import swc_pkg::*; #(
	parameter int ADDR_BITS   = ADDR_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int SET_BITS    = SET_BITS_DEF,
	parameter int WAYS        = WAYS_DEF,
	localparam int WAY_BITS   = $clog2(WAYS)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	input  wire logic [WAY_BITS-1:0] way,
	output sts_t                     sts,
	input  wire logic [1:0]          in_op,
	input  wire logic [ADDR_W-1:0]   in_address,
	input  wire logic [BYTE_W-1:0]   in_store_data,
	output logic [BYTE_W-1:0]        out_read_data,
	output logic                     out_hit
);

	localparam int TAG_SHIFT  = OFFSET_BITS + SET_BITS;
	localparam int TAG_BITS   = ADDR_BITS - TAG_SHIFT;
	localparam int META_W     = TAG_BITS + 2;
	localparam int SET_COUNT  = 1 << SET_BITS;
	localparam int LINE_BYTES = 1 << OFFSET_BITS;
	localparam int ROW_BITS   = ADDR_BITS - OFFSET_BITS;
	localparam int LIDX_BITS  = SET_BITS + WAY_BITS;

	typedef logic [LINE_BYTES-1:0][BYTE_W-1:0] line_t;
	typedef logic [WAYS-1:0][META_W-1:0] row_t;

	// meta entry: bit 0 dirty, bit 1 accessed, tag above
	row_t  meta_mem [SET_COUNT];
	line_t data_mem [1 << LIDX_BITS];
	line_t back_mem [1 << ROW_BITS];

	row_t  meta_rd_q, row_q, meta_wd;
	line_t data_rd_q, back_rd_q, hit_line, fill_line;
	logic  [SET_COUNT-1:0][WAYS-1:0] vld_q;

	logic [ADDR_BITS-1:0]   addr_in;
	op_t                    op_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [SET_BITS-1:0]    set_q;
	logic [TAG_BITS-1:0]    tag_q;
	logic [BYTE_W-1:0]      wd_q, rdata_q;
	logic                   hit_q;
	logic [WAY_BITS-1:0]    hway_q, victim_q, hit_way, inv_way;
	logic [WAYS-1:0]        match;
	logic                   any_inv;
	logic [ROW_BITS-1:0]    clr_cnt_q, back_addr;
	logic [LIDX_BITS-1:0]   data_ra, data_wa;
	logic                   data_we, meta_we;
	logic [TAG_BITS-1:0]    wb_tag;

	assign addr_in = ADDR_BITS'({16'd0, in_address});

	// Lookup over the ways of the captured set
	always_comb begin
		match   = '0;
		hit_way = '0;
		inv_way = '0;
		any_inv = 1'b0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			match[w] = vld_q[set_q][w] && (meta_rd_q[w][META_W-1:2] == tag_q);
			if (match[w]) begin
				hit_way = WAY_BITS'(w);
			end
			if (!vld_q[set_q][w]) begin
				inv_way = WAY_BITS'(w);
				any_inv = 1'b1;
			end
		end
	end

	assign wb_tag = row_q[way][META_W-1:2];

	always_comb begin
		hit_line = data_rd_q;
		fill_line = back_rd_q;
		if (op_q == OP_STORE) begin
			hit_line[off_q]  = wd_q;
			fill_line[off_q] = wd_q;
		end
		meta_wd = row_q;
		if (cmd.hit_wr) begin
			meta_wd = meta_rd_q;
			meta_wd[hit_way][1] = 1'b1;
			if (op_q == OP_STORE) begin
				meta_wd[hit_way][0] = 1'b1;
			end
		end else begin
			meta_wd[victim_q] = {tag_q, 1'b0, op_q == OP_STORE};
		end
	end

	assign meta_we   = cmd.hit_wr || cmd.fill_wr;
	assign data_ra   = cmd.hit_wr ? {set_q, hit_way} : {set_q, way};
	assign data_wa   = cmd.hdata ? {set_q, hway_q} : {set_q, victim_q};
	assign data_we   = (cmd.hdata && op_q == OP_STORE) || cmd.fill_wr;
	assign back_addr = cmd.clr ? clr_cnt_q :
		(cmd.wb_wr ? {wb_tag, set_q} : {tag_q, set_q});

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			meta_rd_q <= meta_mem[addr_in[OFFSET_BITS +: SET_BITS]];
		end
		if (meta_we) begin
			meta_mem[set_q] <= meta_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hit_wr || cmd.wb_rd) begin
			data_rd_q <= data_mem[data_ra];
		end
		if (data_we) begin
			data_mem[data_wa] <= cmd.hdata ? hit_line : fill_line;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_rd) begin
			back_rd_q <= back_mem[back_addr];
		end
		if (cmd.clr || cmd.wb_wr) begin
			back_mem[back_addr] <= cmd.clr ? '0 : data_rd_q;
		end
	end

	// Request fields and working registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q  <= op_t'(in_op);
			off_q <= addr_in[OFFSET_BITS-1:0];
			set_q <= addr_in[OFFSET_BITS +: SET_BITS];
			tag_q <= addr_in[ADDR_BITS-1:TAG_SHIFT];
			wd_q  <= in_store_data;
		end
		if (cmd.hit_wr) begin
			hway_q <= hit_way;
		end
		if (cmd.vic_inv) begin
			victim_q <= inv_way;
		end else if (cmd.vic_walk) begin
			victim_q <= way;
		end
		if (cmd.row_ld) begin
			row_q <= meta_rd_q;
		end else begin
			if (cmd.clr_acc) begin
				row_q[way][1] <= 1'b0;
			end
			if (cmd.clr_dirty) begin
				row_q[way][0] <= 1'b0;
			end
		end
		if (cmd.cap) begin
			rdata_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (cmd.res_hit) begin
				hit_q <= (|match) && (op_q != OP_FLUSH);
			end
			if (cmd.hdata && op_q == OP_LOAD) begin
				rdata_q <= data_rd_q[off_q];
			end else if (cmd.fill_wr && op_q == OP_LOAD) begin
				rdata_q <= back_rd_q[off_q];
			end
		end
		if (cmd.out_ld) begin
			out_read_data <= rdata_q;
			out_hit       <= hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.flush) begin
				vld_q <= '0;
			end else if (cmd.inv && (|match)) begin
				vld_q[set_q][hit_way] <= 1'b0;
			end else if (cmd.fill_wr) begin
				vld_q[set_q][victim_q] <= 1'b1;
			end
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.hit       = |match;
		sts.any_inv   = any_inv;
		sts.cur_acc   = row_q[way][1];
		sts.cur_dirty = row_q[way][0];
		sts.clr_last  = &clr_cnt_q;
	end

endmodule

`default_nettype wire

FILE: design/swc_ctrl.sv
`default_nettype none

module swc_ctrl import swc_pkg::*; #(
	parameter int WAYS      = WAYS_DEF,
	localparam int WAY_BITS = $clog2(WAYS)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output cmd_t                     cmd,
	output logic [WAY_BITS-1:0]      way,
	input  wire sts_t                sts
);

	typedef enum logic [9:0] {
		S_CLEAR   = 10'b00_0000_0001,
		S_IDLE    = 10'b00_0000_0010,
		S_CMP     = 10'b00_0000_0100,
		S_HDATA   = 10'b00_0000_1000,
		S_WALK    = 10'b00_0001_0000,
		S_WB_RD   = 10'b00_0010_0000,
		S_WB_WR   = 10'b00_0100_0000,
		S_FILL_RD = 10'b00_1000_0000,
		S_FILL_WR = 10'b01_0000_0000,
		S_DONE    = 10'b10_0000_0000
	} state_t;

	state_t              state_q, state_d;
	logic [WAY_BITS-1:0] way_q, way_d;
	logic [1:0]          pass_q, pass_d;
	logic                adv, m_tvalid_q;

	assign way      = way_q;
	assign m_tvalid = m_tvalid_q;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		way_d   = way_q;
		pass_d  = pass_q;
		adv     = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				cmd.res_hit = 1'b1;
				if (sts.op == OP_FLUSH) begin
					cmd.flush = 1'b1;
					state_d = S_DONE;
				end else if (sts.op == OP_INV) begin
					cmd.inv = 1'b1;
					state_d = S_DONE;
				end else if (sts.hit) begin
					cmd.hit_wr = 1'b1;
					state_d = S_HDATA;
				end else begin
					cmd.row_ld = 1'b1;
					if (sts.any_inv) begin
						cmd.vic_inv = 1'b1;
						state_d = S_FILL_RD;
					end else begin
						way_d   = '0;
						pass_d  = '0;
						state_d = S_WALK;
					end
				end
			end
			S_HDATA: begin
				cmd.hdata = 1'b1;
				state_d = S_DONE;
			end
			S_WALK: begin
				if (!sts.cur_acc && !sts.cur_dirty) begin
					cmd.vic_walk = 1'b1;
					state_d = S_FILL_RD;
				end else begin
					case (pass_q)
						2'd0: begin
							cmd.clr_acc = sts.cur_acc && !sts.cur_dirty;
							adv = 1'b1;
						end
						2'd1: begin
							if (!sts.cur_acc && sts.cur_dirty) begin
								state_d = S_WB_RD;
							end else begin
								adv = 1'b1;
							end
						end
						2'd2: begin
							if (sts.cur_acc && sts.cur_dirty) begin
								state_d = S_WB_RD;
							end else begin
								adv = 1'b1;
							end
						end
						default: begin
							adv = 1'b1;
						end
					endcase
				end
			end
			S_WB_RD: begin
				cmd.wb_rd = 1'b1;
				state_d = S_WB_WR;
			end
			S_WB_WR: begin
				cmd.wb_wr     = 1'b1;
				cmd.clr_dirty = 1'b1;
				cmd.clr_acc   = (pass_q == 2'd2);
				adv           = 1'b1;
				state_d       = S_WALK;
			end
			S_FILL_RD: begin
				cmd.fill_rd = 1'b1;
				state_d = S_FILL_WR;
			end
			S_FILL_WR: begin
				cmd.fill_wr = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (adv) begin
			if (way_q == WAY_BITS'(WAYS - 1)) begin
				way_d  = '0;
				pass_d = pass_q + 2'd1;
			end else begin
				way_d = way_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			way_q      <= '0;
			pass_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			way_q   <= way_d;
			pass_q  <= pass_d;
			if (cmd.out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_cap_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |=> state_q == S_CMP)
		else $error("accepted request did not reach lookup");
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !s_tready)
		else $error("request taken during backing memory clear");
	a_last_pass_finds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && pass_q == 2'd3) |-> (!sts.cur_acc && !sts.cur_dirty))
		else $error("victim search reached last pass with a used way");
`endif

endmodule

`default_nettype wire

FILE: design/set_associative_writeback_cache.sv
//  channel | dir | signals                   | content (low bit first)
//  s_      | in  | tvalid tready tdata tuser | tdata: address[15:0] store_data[23:16]
//          |     |                           | tuser: operation[1:0]
//  m_      | out | tvalid tready tdata       | tdata: read_data[7:0] hit[8]
//
//  Hit: accept, tag compare, data line access, result.
//  Miss with a free way: the data line access is replaced by a backing
//  line read and a line install. A full set adds the victim search, one way
//  per step, and a line read and a line write per dirty line written back.
//  Invalidate and flush: accept, tag compare, result. One transaction at a
//  time, set by the FSM. After reset the backing memory is zeroed one line
//  per cycle, all 2^(ADDR_BITS-OFFSET_BITS) lines (1024 at default), s_tready
//  low meanwhile. A finished result sits in the output register; a stalled
//  m_ side holds the FSM in its result state until the register frees.
`default_nettype none

module set_associative_writeback_cache import swc_pkg::*; #(
	parameter int ADDR_BITS   = ADDR_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int SET_BITS    = SET_BITS_DEF,
	parameter int WAYS        = WAYS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // address[15:0], store_data[23:16]
	input  wire logic [1:0]  s_tuser,   // operation[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // read_data[7:0], hit[8], zero above
);

	localparam int WAY_BITS = $clog2(WAYS);

	cmd_t                cmd;
	sts_t                sts;
	logic [WAY_BITS-1:0] way;
	logic [BYTE_W-1:0]   read_data;
	logic                hit;

	// Sequencer: lookup, victim search passes, writeback and fill
	swc_ctrl #(
		.WAYS(WAYS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.way     (way),
		.sts     (sts)
	);

	// Tag, line and backing memories with the result register
	swc_dp #(
		.ADDR_BITS  (ADDR_BITS),
		.OFFSET_BITS(OFFSET_BITS),
		.SET_BITS   (SET_BITS),
		.WAYS       (WAYS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.way          (way),
		.sts          (sts),
		.in_op        (s_tuser),
		.in_address   (s_tdata[15:0]),
		.in_store_data(s_tdata[23:16]),
		.out_read_data(read_data),
		.out_hit      (hit)
	);

	assign m_tdata = {7'd0, hit, read_data};

endmodule

`default_nettype wire
